// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every edge once reset is released.
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, also during reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_ON_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/htcc_pkg.sv =====
// Types, codes and constants of the humidity/temperature convert and check unit.
`default_nettype none
package htcc_pkg;
	localparam logic [1:0] OP_HUMIDITY    = 2'd0;
	localparam logic [1:0] OP_TEMPERATURE = 2'd1;
	localparam logic [1:0] OP_PREV_TEMP   = 2'd2;

	localparam logic [1:0] ST_MATCH     = 2'd0;
	localparam logic [1:0] ST_MISMATCH  = 2'd1;
	localparam logic [1:0] ST_UNCHECKED = 2'd2;

	localparam logic [14:0] HUM_SCALE = 15'd12500;
	localparam logic [14:0] TMP_SCALE = 15'd17572;
	localparam logic signed [15:0] HUM_OFFSET = 16'sd600;
	localparam logic signed [15:0] TMP_OFFSET = 16'sd4685;
	localparam logic signed [15:0] HUM_MAX    = 16'sd10000;

	localparam logic [7:0] CRC_POLY = 8'h31;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] raw_code;
		logic [7:0]  check_byte;
	} frame_t;

	typedef struct packed {
		logic signed [14:0] value_centi;
		logic [1:0]         check_status;
		logic               was_clamped;
	} result_t;
endpackage
`default_nettype wire

// ===== hw/rtl/htcc_crc8.sv =====
// CRC-8 (poly 0x31, init 0, MSB first) over the two code bytes, compared with the check byte.
`default_nettype none
module htcc_crc8 (
	input  wire logic [15:0] raw_code,
	input  wire logic [7:0]  check_byte,
	output logic             match
);
	function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] v;
		v = crc ^ b;
		for (int k = 0; k < 8; k++) begin
			if (v[7]) begin
				v = {v[6:0], 1'b0} ^ htcc_pkg::CRC_POLY;
			end else begin
				v = {v[6:0], 1'b0};
			end
		end
		return v;
	endfunction

	logic [7:0] crc_hi;
	logic [7:0] crc_lo;

	assign crc_hi = crc_byte(8'h00, raw_code[15:8]);
	assign crc_lo = crc_byte(crc_hi, raw_code[7:0]);
	assign match  = (crc_lo == check_byte);
endmodule
`default_nettype wire

// ===== hw/rtl/htcc_scale.sv =====
// Code to hundredths: one constant multiply, offset, and humidity saturation.
`default_nettype none
module htcc_scale (
	input  wire logic [1:0]         operation,
	input  wire logic [15:0]        raw_code,
	output logic signed [14:0]      value_centi,
	output logic                    was_clamped
);
	logic               is_hum;
	logic [14:0]        factor;
	logic [30:0]        prod;
	logic signed [15:0] diff;

	assign is_hum = (operation == htcc_pkg::OP_HUMIDITY);
	assign factor = is_hum ? htcc_pkg::HUM_SCALE : htcc_pkg::TMP_SCALE;
	assign prod   = 31'(raw_code) * 31'(factor);
	// prod[30:16] is at most 17571, so the zero-extended value stays positive
	assign diff   = $signed({1'b0, prod[30:16]})
		- (is_hum ? htcc_pkg::HUM_OFFSET : htcc_pkg::TMP_OFFSET);

	always_comb begin
		value_centi = diff[14:0];
		was_clamped = 1'b0;
		if (is_hum) begin
			if (diff < 16'sd0) begin
				value_centi = 15'sd0;
				was_clamped = 1'b1;
			end else if (diff > htcc_pkg::HUM_MAX) begin
				value_centi = htcc_pkg::HUM_MAX[14:0];
				was_clamped = 1'b1;
			end
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/humidity_temperature_convert_check_unit.sv =====
// Top level: frame register, convert/check logic, result register.
//
//   channel  | valid         | stall         | payload
//   frame    | frame_valid   | frame_stall   | frame  (htcc_pkg::frame_t)
//   result   | result_valid  | result_stall  | result (htcc_pkg::result_t)
//
// One frame per cycle sustained while the result is not stalled. The edge that takes a frame
// loads the frame register; the result register is loaded from it (one multiply and CRC in
// between) once the result stage can advance, and result_valid rises as it is loaded.
// Reset clears both valid flags; payload registers are not reset.
// A stalled result holds in place; frame_stall rises only when both stages are full
// and the result is stalled.
`default_nettype none
`include "assert_macros.svh"
module humidity_temperature_convert_check_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             frame_valid,
	output logic                  frame_stall,
	input  wire htcc_pkg::frame_t frame,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output htcc_pkg::result_t     result
);
	htcc_pkg::frame_t  frame_s1;
	logic              valid_s1;
	htcc_pkg::result_t result_s2;
	logic              valid_s2;

	logic              adv2;
	logic              take;
	logic              crc_match;
	logic signed [14:0] value_c;
	logic              clamped_c;
	logic [1:0]        status_c;

	assign adv2        = !valid_s2 || !result_stall;
	assign frame_stall = valid_s1 && !adv2;
	assign take        = frame_valid && !frame_stall;

	htcc_scale u_scale (
		.operation   (frame_s1.operation),
		.raw_code    (frame_s1.raw_code),
		.value_centi (value_c),
		.was_clamped (clamped_c)
	);

	htcc_crc8 u_crc (
		.raw_code   (frame_s1.raw_code),
		.check_byte (frame_s1.check_byte),
		.match      (crc_match)
	);

	always_comb begin
		case (frame_s1.operation)
			htcc_pkg::OP_HUMIDITY,
			htcc_pkg::OP_TEMPERATURE: status_c = crc_match ? htcc_pkg::ST_MATCH
				: htcc_pkg::ST_MISMATCH;
			default:                  status_c = htcc_pkg::ST_UNCHECKED;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (!frame_stall) begin
				valid_s1 <= frame_valid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			frame_s1 <= frame;
		end
		if (adv2 && valid_s1) begin
			result_s2.value_centi  <= value_c;
			result_s2.check_status <= status_c;
			result_s2.was_clamped  <= clamped_c;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	`ASSERT_ALWAYS(a_stall_only_when_full, clk,
		frame_stall |-> (valid_s1 && valid_s2 && result_stall),
		"frame stalled while a stage is free")
	`ASSERT_ON_CLK(a_s1_moves_to_s2, clk, arst_n,
		(valid_s1 && adv2) |=> valid_s2,
		"transaction lost between frame and result register")
	`ASSERT_ON_CLK(a_clamp_bounds, clk, arst_n,
		(valid_s2 && result_s2.was_clamped) |->
		(result_s2.value_centi == 15'sd0
		|| result_s2.value_centi == htcc_pkg::HUM_MAX[14:0]),
		"clamped result not at a humidity bound")
	`ASSERT_ON_CLK(a_status_code, clk, arst_n,
		valid_s2 |-> (result_s2.check_status == htcc_pkg::ST_MATCH
		|| result_s2.check_status == htcc_pkg::ST_MISMATCH
		|| result_s2.check_status == htcc_pkg::ST_UNCHECKED),
		"reserved check status code")
endmodule
`default_nettype wire
